// ===== src/sdc_pkg.sv =====
// ----------------------------------------------------------------------------
// SD card sequencer package
// Shared types, codes, command flags and the clock divider function.
// ----------------------------------------------------------------------------
package sdc_pkg;

  // Sizes of the data blocks and of the switch function status read.
  localparam int unsigned BlockBytes        = 512;
  localparam int unsigned BlockShift        = $clog2(BlockBytes);
  localparam int unsigned SwitchStatusBytes = 64;
  localparam int unsigned MaxDivShift       = 10;

  // Event codes carried by an input item.
  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_CMD_OK    = 3'd1,
    OP_CMD_ERR   = 3'd2,
    OP_DATA_OK   = 3'd3,
    OP_DATA_ERR  = 3'd4,
    OP_READ_REQ  = 3'd5,
    OP_WRITE_REQ = 3'd6
  } sdc_op_e;

  // Status codes carried by a result item.
  typedef enum logic [2:0] {
    ST_INIT_BUSY   = 3'd0,
    ST_READY       = 3'd1,
    ST_INIT_FAILED = 3'd2,
    ST_XFER_BUSY   = 3'd3,
    ST_XFER_DONE   = 3'd4,
    ST_XFER_ERROR  = 3'd5,
    ST_NOT_READY   = 3'd6,
    ST_IGNORED     = 3'd7
  } sdc_status_e;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE, PH_FAILED, PH_CMD0, PH_CMD8, PH_APP41, PH_ACMD41, PH_CMD2,
    PH_CMD3, PH_CMD7, PH_CMD16, PH_APP6, PH_ACMD6, PH_CMD6, PH_SWDATA,
    PH_READY, PH_XCMD, PH_XDATA
  } sdc_phase_e;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_BASE_CLOCK  = 1'b0,
    REG_RETRY_LIMIT = 1'b1
  } sdc_reg_e;

  // Command indexes.
  localparam logic [7:0] CmdGoIdle      = 8'd0;
  localparam logic [7:0] CmdAllSendCid  = 8'd2;
  localparam logic [7:0] CmdSendRca     = 8'd3;
  localparam logic [7:0] CmdSwitch      = 8'd6;
  localparam logic [7:0] CmdSetBusWidth = 8'd6;
  localparam logic [7:0] CmdSelect      = 8'd7;
  localparam logic [7:0] CmdIfCond      = 8'd8;
  localparam logic [7:0] CmdSetBlkLen   = 8'd16;
  localparam logic [7:0] CmdReadSingle  = 8'd17;
  localparam logic [7:0] CmdReadMulti   = 8'd18;
  localparam logic [7:0] CmdWriteSingle = 8'd24;
  localparam logic [7:0] CmdWriteMulti  = 8'd25;
  localparam logic [7:0] CmdOpCond      = 8'd41;
  localparam logic [7:0] CmdAppCmd      = 8'd55;

  // Command and transfer mode flags.
  localparam logic [31:0] RspR136     = 32'h0001_0000;
  localparam logic [31:0] RspR48      = 32'h0002_0000;
  localparam logic [31:0] RspR48b     = 32'h0003_0000;
  localparam logic [31:0] CrcEn       = 32'h0008_0000;
  localparam logic [31:0] DataPresent = 32'h0020_0000;
  localparam logic [31:0] DirRead     = 32'h0000_0010;
  localparam logic [31:0] MultiBlk    = 32'h0000_0020;
  localparam logic [31:0] CountEn     = 32'h0000_0002;
  localparam logic [31:0] AutoCmd12   = 32'h0000_0004;

  // Command arguments and response checks.
  localparam logic [31:0] IfCondArg   = 32'h0000_01AA;
  localparam logic [11:0] IfCondEcho  = 12'h1AA;
  localparam logic [31:0] OpCondArg   = 32'h40FF_8000;
  localparam logic [31:0] SwitchArg   = 32'h80FF_FFF1;
  localparam logic [31:0] BusWidthArg = 32'd2;

  // Card clock targets in Hz.
  localparam logic [25:0] ClkIdentHz = 26'd400000;
  localparam logic [25:0] ClkDefHz   = 26'd25000000;
  localparam logic [25:0] ClkHighHz  = 26'd50000000;

  // One input item.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] response;
    logic [31:0] sector;
    logic [15:0] block_count;
  } sdc_item_t;

  // One result item.
  typedef struct packed {
    logic        cmd_valid;
    logic [31:0] cmd_word;
    logic [31:0] cmd_arg;
    logic        blk_valid;
    logic [31:0] block_size_count;
    logic        clock_valid;
    logic [9:0]  clock_divider;
    logic        bus_four_bit;
    logic [2:0]  status;
    logic        high_capacity;
    logic [15:0] card_address;
  } sdc_result_t;

  // Divider values for the three card clock rates.
  typedef struct packed {
    logic [9:0] div_ident;
    logic [9:0] div_def;
    logic [9:0] div_high;
  } sdc_divs_t;

  // Smallest power of two 2^s with base <= target * 2^s, s capped at
  // MaxDivShift; the divider register takes 2^(s-1), or zero for s of zero.
  function automatic logic [9:0] clk_div(input logic [29:0] base,
                                         input logic [25:0] target);
    logic [3:0]  s;
    logic        found;
    logic [35:0] lim;
    s     = 4'(MaxDivShift);
    found = 1'b0;
    for (int i = 0; i <= int'(MaxDivShift); i++) begin
      lim = 36'(target) << i;
      if (!found && (36'(base) <= lim)) begin
        s     = 4'(i);
        found = 1'b1;
      end
    end
    if (s == 4'd0) begin
      return 10'd0;
    end
    return 10'd1 << (s - 4'd1);
  endfunction

endpackage

// ===== src/sdc_req_if.sv =====
// ----------------------------------------------------------------------------
// SD card sequencer event channel
// Valid/ready channel that carries one event item to the sequencer.
// ----------------------------------------------------------------------------
interface sdc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [31:0] response;
  logic [31:0] sector;
  logic [15:0] block_count;

  modport source (output valid, opcode, response, sector, block_count, input ready);
  modport sink (input valid, opcode, response, sector, block_count, output ready);
endinterface

// ===== src/sdc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// SD card sequencer result channel
// Valid/ready channel that carries one result item from the sequencer.
// ----------------------------------------------------------------------------
interface sdc_rsp_if;
  logic        valid;
  logic        ready;
  logic        cmd_valid;
  logic [31:0] cmd_word;
  logic [31:0] cmd_arg;
  logic        blk_valid;
  logic [31:0] block_size_count;
  logic        clock_valid;
  logic [9:0]  clock_divider;
  logic        bus_four_bit;
  logic [2:0]  status;
  logic        high_capacity;
  logic [15:0] card_address;

  modport source (
    output valid, cmd_valid, cmd_word, cmd_arg, blk_valid, block_size_count,
           clock_valid, clock_divider, bus_four_bit, status, high_capacity,
           card_address,
    input  ready
  );
  modport sink (
    input  valid, cmd_valid, cmd_word, cmd_arg, blk_valid, block_size_count,
           clock_valid, clock_divider, bus_four_bit, status, high_capacity,
           card_address,
    output ready
  );
endinterface

// ===== src/sdc_clkdiv.sv =====
// ----------------------------------------------------------------------------
// SD card clock divider calculation
// Derives the identification, default and high speed dividers from the
// configured base clock with a row of constant threshold compares.
// ----------------------------------------------------------------------------
module sdc_clkdiv (
  input  logic [29:0]        base_clock_i,
  output sdc_pkg::sdc_divs_t divs_o
);

  // Each divider is an independent set of compares against constants.
  always_comb begin
    divs_o.div_ident = sdc_pkg::clk_div(base_clock_i, sdc_pkg::ClkIdentHz);
    divs_o.div_def   = sdc_pkg::clk_div(base_clock_i, sdc_pkg::ClkDefHz);
    divs_o.div_high  = sdc_pkg::clk_div(base_clock_i, sdc_pkg::ClkHighHz);
  end

endmodule

// ===== src/sdc_fsm.sv =====
// ----------------------------------------------------------------------------
// SD card sequencer state machine
// Holds the card state and works out the next state and the result for
// the item in the input register.
// ----------------------------------------------------------------------------
module sdc_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  sdc_pkg::sdc_item_t   item_i,
  input  logic [7:0]           retry_limit_i,
  input  sdc_pkg::sdc_divs_t   divs_i,
  output sdc_pkg::sdc_result_t result_o
);

  sdc_pkg::sdc_phase_e phase_q, phase_d;
  logic                sdhc_q, sdhc_d;
  logic [15:0]         rca_q, rca_d;
  logic [7:0]          retry_q, retry_d;
  logic                four_q, four_d;
  logic [7:0]          retry_inc;
  logic                cok;
  logic                cerr;
  sdc_pkg::sdc_status_e st;

  // State registers advance only when the item moves to the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= sdc_pkg::PH_IDLE;
      sdhc_q  <= 1'b0;
      rca_q   <= '0;
      retry_q <= '0;
      four_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      sdhc_q  <= sdhc_d;
      rca_q   <= rca_d;
      retry_q <= retry_d;
      four_q  <= four_d;
    end
  end

  assign cok       = (item_i.opcode == sdc_pkg::OP_CMD_OK);
  assign cerr      = (item_i.opcode == sdc_pkg::OP_CMD_ERR);
  assign retry_inc = (retry_q != 8'hFF) ? retry_q + 8'd1 : retry_q;

  // Next state and result for one event.
  always_comb begin
    phase_d  = phase_q;
    sdhc_d   = sdhc_q;
    rca_d    = rca_q;
    retry_d  = retry_q;
    four_d   = four_q;
    st       = sdc_pkg::ST_IGNORED;
    result_o = '0;

    case (item_i.opcode)
      sdc_pkg::OP_START: begin
        sdhc_d  = 1'b0;
        rca_d   = '0;
        retry_d = '0;
        four_d  = 1'b0;
        result_o.clock_valid   = 1'b1;
        result_o.clock_divider = divs_i.div_ident;
        result_o.cmd_valid     = 1'b1;
        result_o.cmd_word      = {sdc_pkg::CmdGoIdle, 24'h0};
        phase_d = sdc_pkg::PH_CMD0;
        st      = sdc_pkg::ST_INIT_BUSY;
      end

      sdc_pkg::OP_READ_REQ, sdc_pkg::OP_WRITE_REQ: begin
        if (phase_q == sdc_pkg::PH_READY) begin
          if (item_i.block_count == 16'd0) begin
            st = sdc_pkg::ST_XFER_DONE;
          end else begin
            result_o.cmd_valid = 1'b1;
            result_o.cmd_arg   = sdhc_q ? item_i.sector
                                        : (item_i.sector << sdc_pkg::BlockShift);
            result_o.cmd_word  = sdc_pkg::RspR48 | sdc_pkg::CrcEn | sdc_pkg::DataPresent;
            if (item_i.opcode == sdc_pkg::OP_READ_REQ) begin
              result_o.cmd_word = result_o.cmd_word | sdc_pkg::DirRead;
            end
            if (item_i.block_count == 16'd1) begin
              result_o.cmd_word = result_o.cmd_word |
                ((item_i.opcode == sdc_pkg::OP_READ_REQ) ?
                 {sdc_pkg::CmdReadSingle, 24'h0} : {sdc_pkg::CmdWriteSingle, 24'h0});
            end else begin
              result_o.cmd_word = result_o.cmd_word | sdc_pkg::MultiBlk |
                sdc_pkg::CountEn | sdc_pkg::AutoCmd12 |
                ((item_i.opcode == sdc_pkg::OP_READ_REQ) ?
                 {sdc_pkg::CmdReadMulti, 24'h0} : {sdc_pkg::CmdWriteMulti, 24'h0});
            end
            result_o.blk_valid        = 1'b1;
            result_o.block_size_count = {item_i.block_count, 16'(sdc_pkg::BlockBytes)};
            phase_d = sdc_pkg::PH_XCMD;
            st      = sdc_pkg::ST_XFER_BUSY;
          end
        end else if ((phase_q == sdc_pkg::PH_XCMD) || (phase_q == sdc_pkg::PH_XDATA)) begin
          st = sdc_pkg::ST_IGNORED;
        end else begin
          st = sdc_pkg::ST_NOT_READY;
        end
      end

      sdc_pkg::OP_CMD_OK, sdc_pkg::OP_CMD_ERR: begin
        st = sdc_pkg::ST_INIT_BUSY;
        case (phase_q)
          sdc_pkg::PH_CMD0: begin
            if (cok) begin
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdIfCond, 24'h0} | sdc_pkg::RspR48 |
                                   sdc_pkg::CrcEn;
              result_o.cmd_arg   = sdc_pkg::IfCondArg;
              phase_d = sdc_pkg::PH_CMD8;
            end else begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end
          end
          sdc_pkg::PH_CMD8: begin
            // A failed CMD8 marks an older card and is tolerated.
            if (cok && (item_i.response[11:0] != sdc_pkg::IfCondEcho)) begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end else begin
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdAppCmd, 24'h0} | sdc_pkg::RspR48 |
                                   sdc_pkg::CrcEn;
              result_o.cmd_arg   = {rca_q, 16'h0};
              phase_d = sdc_pkg::PH_APP41;
            end
          end
          sdc_pkg::PH_APP41: begin
            if (cok) begin
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdOpCond, 24'h0} | sdc_pkg::RspR48;
              result_o.cmd_arg   = sdc_pkg::OpCondArg;
              phase_d = sdc_pkg::PH_ACMD41;
            end else begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end
          end
          sdc_pkg::PH_ACMD41: begin
            if (cerr) begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end else if (item_i.response[31]) begin
              // Power-up done: latch capacity and move to the default clock.
              sdhc_d = item_i.response[30];
              result_o.clock_valid   = 1'b1;
              result_o.clock_divider = divs_i.div_def;
              result_o.cmd_valid     = 1'b1;
              result_o.cmd_word      = {sdc_pkg::CmdAllSendCid, 24'h0} |
                                       sdc_pkg::RspR136 | sdc_pkg::CrcEn;
              phase_d = sdc_pkg::PH_CMD2;
            end else begin
              retry_d = retry_inc;
              if (retry_inc >= retry_limit_i) begin
                phase_d = sdc_pkg::PH_FAILED;
                st      = sdc_pkg::ST_INIT_FAILED;
              end else begin
                result_o.cmd_valid = 1'b1;
                result_o.cmd_word  = {sdc_pkg::CmdAppCmd, 24'h0} | sdc_pkg::RspR48 |
                                     sdc_pkg::CrcEn;
                result_o.cmd_arg   = {rca_q, 16'h0};
                phase_d = sdc_pkg::PH_APP41;
              end
            end
          end
          sdc_pkg::PH_CMD2: begin
            if (cok) begin
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdSendRca, 24'h0} | sdc_pkg::RspR48 |
                                   sdc_pkg::CrcEn;
              phase_d = sdc_pkg::PH_CMD3;
            end else begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end
          end
          sdc_pkg::PH_CMD3: begin
            if (cok) begin
              rca_d = item_i.response[31:16];
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdSelect, 24'h0} | sdc_pkg::RspR48b |
                                   sdc_pkg::CrcEn;
              result_o.cmd_arg   = {item_i.response[31:16], 16'h0};
              phase_d = sdc_pkg::PH_CMD7;
            end else begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end
          end
          sdc_pkg::PH_CMD7, sdc_pkg::PH_CMD16: begin
            if (cerr) begin
              phase_d = sdc_pkg::PH_FAILED;
              st      = sdc_pkg::ST_INIT_FAILED;
            end else if ((phase_q == sdc_pkg::PH_CMD7) && !sdhc_q) begin
              // Standard capacity cards need the block length set.
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdSetBlkLen, 24'h0} | sdc_pkg::RspR48 |
                                   sdc_pkg::CrcEn;
              result_o.cmd_arg   = 32'(sdc_pkg::BlockBytes);
              phase_d = sdc_pkg::PH_CMD16;
            end else begin
              result_o.blk_valid        = 1'b1;
              result_o.block_size_count = 32'(sdc_pkg::BlockBytes);
              result_o.cmd_valid        = 1'b1;
              result_o.cmd_word         = {sdc_pkg::CmdAppCmd, 24'h0} |
                                          sdc_pkg::RspR48 | sdc_pkg::CrcEn;
              result_o.cmd_arg          = {rca_q, 16'h0};
              phase_d = sdc_pkg::PH_APP6;
            end
          end
          sdc_pkg::PH_APP6, sdc_pkg::PH_ACMD6: begin
            if ((phase_q == sdc_pkg::PH_APP6) && cok) begin
              result_o.cmd_valid = 1'b1;
              result_o.cmd_word  = {sdc_pkg::CmdSetBusWidth, 24'h0} | sdc_pkg::RspR48 |
                                   sdc_pkg::CrcEn;
              result_o.cmd_arg   = sdc_pkg::BusWidthArg;
              phase_d = sdc_pkg::PH_ACMD6;
            end else begin
              // Bus width done or skipped: go on with the high speed switch.
              if ((phase_q == sdc_pkg::PH_ACMD6) && cok) begin
                four_d = 1'b1;
              end
              result_o.cmd_valid        = 1'b1;
              result_o.cmd_word         = {sdc_pkg::CmdSwitch, 24'h0} | sdc_pkg::RspR48 |
                                          sdc_pkg::CrcEn | sdc_pkg::DataPresent |
                                          sdc_pkg::DirRead;
              result_o.cmd_arg          = sdc_pkg::SwitchArg;
              result_o.blk_valid        = 1'b1;
              result_o.block_size_count = {16'd1, 16'(sdc_pkg::SwitchStatusBytes)};
              phase_d = sdc_pkg::PH_CMD6;
            end
          end
          sdc_pkg::PH_CMD6: begin
            if (cok) begin
              phase_d = sdc_pkg::PH_SWDATA;
            end else begin
              phase_d = sdc_pkg::PH_READY;
              st      = sdc_pkg::ST_READY;
            end
          end
          sdc_pkg::PH_XCMD: begin
            if (cok) begin
              phase_d = sdc_pkg::PH_XDATA;
              st      = sdc_pkg::ST_XFER_BUSY;
            end else begin
              phase_d = sdc_pkg::PH_READY;
              st      = sdc_pkg::ST_XFER_ERROR;
            end
          end
          default: begin
            st = sdc_pkg::ST_IGNORED;
          end
        endcase
      end

      sdc_pkg::OP_DATA_OK, sdc_pkg::OP_DATA_ERR: begin
        if (phase_q == sdc_pkg::PH_SWDATA) begin
          if (item_i.opcode == sdc_pkg::OP_DATA_OK) begin
            result_o.clock_valid   = 1'b1;
            result_o.clock_divider = divs_i.div_high;
          end
          phase_d = sdc_pkg::PH_READY;
          st      = sdc_pkg::ST_READY;
        end else if (phase_q == sdc_pkg::PH_XDATA) begin
          phase_d = sdc_pkg::PH_READY;
          st      = (item_i.opcode == sdc_pkg::OP_DATA_OK) ? sdc_pkg::ST_XFER_DONE
                                                           : sdc_pkg::ST_XFER_ERROR;
        end
      end

      default: begin
        st = sdc_pkg::ST_IGNORED;
      end
    endcase

    // Card state fields report the state after this item.
    result_o.bus_four_bit  = four_d;
    result_o.status        = st;
    result_o.high_capacity = sdhc_d;
    result_o.card_address  = rca_d;
  end

  // A start clears the card state and enters the CMD0 phase.
  a_start_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (item_i.opcode == sdc_pkg::OP_START)) |=>
      ((phase_q == sdc_pkg::PH_CMD0) && !sdhc_q && (rca_q == 16'd0) && !four_q))
    else $error("start did not restart initialisation");

  // The retry count only falls on a start.
  a_retry_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire_i && (item_i.opcode != sdc_pkg::OP_START)) |=> (retry_q >= $past(retry_q)))
    else $error("retry count fell without a start");

endmodule

// ===== src/sd_card_init_and_transfer_sequencer.sv =====
// ----------------------------------------------------------------------------
// SD card initialisation and transfer sequencer
// Host-side command sequencer for card bring-up and block transfers.
// ----------------------------------------------------------------------------
// Usage:
//   Events (start, command done, data done, read or write request) arrive as
//   items on the req_i channel; every event yields exactly one result item on
//   rsp_o, telling the host which command to issue, whether a block size or
//   count word and a clock divider must be written, and the status.
//   Configuration (base clock, ACMD41 retry limit) is written through the
//   cfg_we_i / cfg_idx_i / cfg_wdata_i port; the user must write it only while
//   no event is in flight, which the block does not enforce. An accepted item
//   is held in an input register; the state machine and the divider compares
//   work on it combinationally and the result goes to the result register.
//   One item per cycle is taken back to back while rsp_o is not stalled,
//   set by the single state machine update per cycle.
//   When rsp_o is stalled the result register holds its item and the input
//   register holds the next one; req_i.ready drops only when both are full.
//   Reset empties both registers, puts the sequencer in its idle, not
//   initialised phase and restores the configuration defaults.
// ----------------------------------------------------------------------------
module sd_card_init_and_transfer_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [29:0] cfg_wdata_i,
  sdc_req_if.sink     req_i,
  sdc_rsp_if.source   rsp_o
);

  logic [29:0]          base_q;
  logic [7:0]           limit_q;
  logic                 in_vld_q;
  sdc_pkg::sdc_item_t   item_q;
  logic                 out_vld_q;
  sdc_pkg::sdc_result_t res_q;
  sdc_pkg::sdc_result_t res;
  sdc_pkg::sdc_divs_t   divs;
  logic                 move;
  logic                 take;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q  <= 30'd100000000;
      limit_q <= 8'd99;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sdc_pkg::REG_BASE_CLOCK:  base_q  <= cfg_wdata_i;
        sdc_pkg::REG_RETRY_LIMIT: limit_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Handshakes: the item moves on when the result register is free.
  assign move        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || move;
  assign take        = req_i.valid && req_i.ready;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (take) begin
      in_vld_q <= 1'b1;
    end else if (move) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q.opcode      <= req_i.opcode;
      item_q.response    <= req_i.response;
      item_q.sector      <= req_i.sector;
      item_q.block_count <= req_i.block_count;
    end
  end

  sdc_clkdiv u_clkdiv (
    .base_clock_i (base_q),
    .divs_o       (divs)
  );

  sdc_fsm u_fsm (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (move),
    .item_i        (item_q),
    .retry_limit_i (limit_q),
    .divs_i        (divs),
    .result_o      (res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (move) begin
      out_vld_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      res_q <= res;
    end
  end

  assign rsp_o.valid            = out_vld_q;
  assign rsp_o.cmd_valid        = res_q.cmd_valid;
  assign rsp_o.cmd_word         = res_q.cmd_word;
  assign rsp_o.cmd_arg          = res_q.cmd_arg;
  assign rsp_o.blk_valid        = res_q.blk_valid;
  assign rsp_o.block_size_count = res_q.block_size_count;
  assign rsp_o.clock_valid      = res_q.clock_valid;
  assign rsp_o.clock_divider    = res_q.clock_divider;
  assign rsp_o.bus_four_bit     = res_q.bus_four_bit;
  assign rsp_o.status           = res_q.status;
  assign rsp_o.high_capacity    = res_q.high_capacity;
  assign rsp_o.card_address     = res_q.card_address;

  // An item that moves on is shown as a result in the next cycle.
  a_move_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_vld_q)
    else $error("moved item did not reach the result register");

  // A command is only issued while initialising or starting a transfer.
  a_cmd_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && res_q.cmd_valid) |->
      ((res_q.status == sdc_pkg::ST_INIT_BUSY) || (res_q.status == sdc_pkg::ST_XFER_BUSY)))
    else $error("command issued with an unexpected status");

  // An empty input register never blocks the event channel.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> req_i.ready)
    else $error("event channel stalled with an empty input register");

endmodule

// ===== verif/sdc_result_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card sequencer result checker
// Watches the event and result channels and the configuration port. It
// predicts the result item for every accepted event and compares each
// delivered result, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module sdc_result_checker
  import sdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [29:0] cfg_wdata_i,
  sdc_req_if          req_mon,
  sdc_rsp_if          rsp_mon,
  output int unsigned mismatch_count,
  output int unsigned results_due
);

  // Own copy of the configuration and the card state.
  logic [29:0] base_hz;
  logic [7:0]  retry_limit;
  sdc_phase_e  card_phase;
  logic        card_hc;
  logic [15:0] card_rca;
  logic [7:0]  op_cond_tries;
  logic        bus_wide;

  // Predicted results, oldest first.
  sdc_result_t due_results[$];

  // Divider for a target rate: ceil(base / target), rounded up to a power of
  // two 2^s with s capped, expressed as 2^(s-1), or zero when s is zero.
  function automatic logic [9:0] divider_for(input logic [25:0] clk_rate);
    longint unsigned ratio;
    int              s;
    ratio = longint'(base_hz) + longint'(clk_rate) - 1;
    ratio = ratio / longint'(clk_rate);
    s     = 0;
    while (s < int'(MaxDivShift) && (64'd1 << s) < ratio) s++;
    return (s == 0) ? 10'd0 : 10'(1 << (s - 1));
  endfunction

  // Valid flag, command word and argument of one issued command.
  function automatic logic [64:0] command(input logic [7:0] idx, input logic [31:0] flags,
                                          input logic [31:0] arg);
    return {1'b1, {idx, 24'd0} | flags, arg};
  endfunction

  function automatic logic [64:0] app_cmd();
    return command(CmdAppCmd, RspR48 | CrcEn, {card_rca, 16'd0});
  endfunction

  // Works out the result of one event and moves the card state on.
  function automatic sdc_result_t next_result(input logic [2:0] op, input logic [31:0] rsp_word,
                                              input logic [31:0] sec, input logic [15:0] cnt);
    sdc_result_t r;
    sdc_status_e st;
    logic [31:0] flags;
    logic [7:0]  idx;
    logic        cmd_ok;
    logic        failed;
    logic        start_switch;
    r            = '0;
    st           = ST_IGNORED;
    cmd_ok       = (op == OP_CMD_OK);
    failed       = 1'b0;
    start_switch = 1'b0;
    case (op)
      OP_START: begin
        card_hc       = 1'b0;
        card_rca      = '0;
        op_cond_tries = '0;
        bus_wide      = 1'b0;
        r.clock_valid   = 1'b1;
        r.clock_divider = divider_for(ClkIdentHz);
        {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdGoIdle, 32'd0, 32'd0);
        card_phase = PH_CMD0;
        st         = ST_INIT_BUSY;
      end
      OP_READ_REQ, OP_WRITE_REQ: begin
        if (card_phase == PH_READY) begin
          if (cnt == 16'd0) begin
            st = ST_XFER_DONE;
          end else begin
            flags = RspR48 | CrcEn | DataPresent | ((op == OP_READ_REQ) ? DirRead : 32'd0);
            if (cnt == 16'd1) begin
              idx = (op == OP_READ_REQ) ? CmdReadSingle : CmdWriteSingle;
            end else begin
              idx   = (op == OP_READ_REQ) ? CmdReadMulti : CmdWriteMulti;
              flags = flags | MultiBlk | CountEn | AutoCmd12;
            end
            // Standard capacity cards take a byte address, which wraps.
            {r.cmd_valid, r.cmd_word, r.cmd_arg} =
              command(idx, flags, card_hc ? sec : 32'(sec * BlockBytes));
            r.blk_valid        = 1'b1;
            r.block_size_count = {cnt, 16'(BlockBytes)};
            card_phase = PH_XCMD;
            st         = ST_XFER_BUSY;
          end
        end else if (card_phase == PH_XCMD || card_phase == PH_XDATA) begin
          st = ST_IGNORED;
        end else begin
          st = ST_NOT_READY;
        end
      end
      OP_CMD_OK, OP_CMD_ERR: begin
        st = ST_INIT_BUSY;
        case (card_phase)
          PH_CMD0: begin
            if (cmd_ok) begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdIfCond, RspR48 | CrcEn,
                                                             IfCondArg);
              card_phase = PH_CMD8;
            end else failed = 1'b1;
          end
          PH_CMD8: begin
            // An older card rejects the interface check; a wrong echo fails.
            if (cmd_ok && rsp_word[11:0] != IfCondEcho) begin
              failed = 1'b1;
            end else begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = app_cmd();
              card_phase = PH_APP41;
            end
          end
          PH_APP41: begin
            if (cmd_ok) begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdOpCond, RspR48, OpCondArg);
              card_phase = PH_ACMD41;
            end else failed = 1'b1;
          end
          PH_ACMD41: begin
            if (!cmd_ok) begin
              failed = 1'b1;
            end else if (rsp_word[31]) begin
              card_hc         = rsp_word[30];
              r.clock_valid   = 1'b1;
              r.clock_divider = divider_for(ClkDefHz);
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdAllSendCid, RspR136 | CrcEn,
                                                             32'd0);
              card_phase = PH_CMD2;
            end else begin
              // Card still busy: count the attempt and retry or give up.
              if (op_cond_tries != 8'hFF) op_cond_tries++;
              if (op_cond_tries >= retry_limit) begin
                failed = 1'b1;
              end else begin
                {r.cmd_valid, r.cmd_word, r.cmd_arg} = app_cmd();
                card_phase = PH_APP41;
              end
            end
          end
          PH_CMD2: begin
            if (cmd_ok) begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdSendRca, RspR48 | CrcEn,
                                                             32'd0);
              card_phase = PH_CMD3;
            end else failed = 1'b1;
          end
          PH_CMD3: begin
            if (cmd_ok) begin
              card_rca = rsp_word[31:16];
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdSelect, RspR48b | CrcEn,
                                                             {card_rca, 16'd0});
              card_phase = PH_CMD7;
            end else failed = 1'b1;
          end
          PH_CMD7, PH_CMD16: begin
            if (!cmd_ok) begin
              failed = 1'b1;
            end else if (card_phase == PH_CMD7 && !card_hc) begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdSetBlkLen, RspR48 | CrcEn,
                                                             32'(BlockBytes));
              card_phase = PH_CMD16;
            end else begin
              r.blk_valid        = 1'b1;
              r.block_size_count = 32'(BlockBytes);
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = app_cmd();
              card_phase = PH_APP6;
            end
          end
          PH_APP6: begin
            if (cmd_ok) begin
              {r.cmd_valid, r.cmd_word, r.cmd_arg} = command(CmdSetBusWidth, RspR48 | CrcEn,
                                                             BusWidthArg);
              card_phase = PH_ACMD6;
            end else start_switch = 1'b1;
          end
          PH_ACMD6: begin
            if (cmd_ok) bus_wide = 1'b1;
            start_switch = 1'b1;
          end
          PH_CMD6: begin
            if (cmd_ok) begin
              card_phase = PH_SWDATA;
            end else begin
              card_phase = PH_READY;
              st         = ST_READY;
            end
          end
          PH_XCMD: begin
            if (cmd_ok) begin
              card_phase = PH_XDATA;
              st         = ST_XFER_BUSY;
            end else begin
              card_phase = PH_READY;
              st         = ST_XFER_ERROR;
            end
          end
          default: st = ST_IGNORED;
        endcase
      end
      OP_DATA_OK, OP_DATA_ERR: begin
        if (card_phase == PH_SWDATA) begin
          // High speed only once the switch status has been read back.
          if (op == OP_DATA_OK) begin
            r.clock_valid   = 1'b1;
            r.clock_divider = divider_for(ClkHighHz);
          end
          card_phase = PH_READY;
          st         = ST_READY;
        end else if (card_phase == PH_XDATA) begin
          card_phase = PH_READY;
          st         = (op == OP_DATA_OK) ? ST_XFER_DONE : ST_XFER_ERROR;
        end
      end
      default: ;
    endcase

    // The high-speed switch command reads a 64-byte status block.
    if (start_switch) begin
      {r.cmd_valid, r.cmd_word, r.cmd_arg} =
        command(CmdSwitch, RspR48 | CrcEn | DataPresent | DirRead, SwitchArg);
      r.blk_valid        = 1'b1;
      r.block_size_count = 32'h0001_0000 | 32'(SwitchStatusBytes);
      card_phase = PH_CMD6;
    end
    if (failed) begin
      card_phase = PH_FAILED;
      st         = ST_INIT_FAILED;
    end

    r.bus_four_bit  = bus_wide;
    r.status        = st;
    r.high_capacity = card_hc;
    r.card_address  = card_rca;
    return r;
  endfunction

  function automatic int field_differs(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  // Configuration writes, result checks and predictions, edge by edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    sdc_result_t want;
    int          n;
    if (!rst_ni) begin
      base_hz        = 30'd100000000;
      retry_limit    = 8'd99;
      card_phase     = PH_IDLE;
      card_hc        = 1'b0;
      card_rca       = '0;
      op_cond_tries  = '0;
      bus_wide       = 1'b0;
      mismatch_count = 0;
      due_results.delete();
      results_due    = 0;
    end else begin
      if (cfg_we_i) begin
        case (sdc_reg_e'(cfg_idx_i))
          REG_BASE_CLOCK:  base_hz     = cfg_wdata_i;
          REG_RETRY_LIMIT: retry_limit = cfg_wdata_i[7:0];
          default: ;
        endcase
      end

      if (rsp_mon.valid && rsp_mon.ready) begin
        if (due_results.size() == 0) begin
          $error("result item arrived with no prediction waiting");
          mismatch_count++;
        end else begin
          want = due_results.pop_front();
          n = 0;
          n += field_differs("cmd_valid", 32'(want.cmd_valid), 32'(rsp_mon.cmd_valid));
          n += field_differs("cmd_word", want.cmd_word, rsp_mon.cmd_word);
          n += field_differs("cmd_arg", want.cmd_arg, rsp_mon.cmd_arg);
          n += field_differs("blk_valid", 32'(want.blk_valid), 32'(rsp_mon.blk_valid));
          n += field_differs("block_size_count", want.block_size_count,
                             rsp_mon.block_size_count);
          n += field_differs("clock_valid", 32'(want.clock_valid),
                             32'(rsp_mon.clock_valid));
          n += field_differs("clock_divider", 32'(want.clock_divider),
                             32'(rsp_mon.clock_divider));
          n += field_differs("bus_four_bit", 32'(want.bus_four_bit),
                             32'(rsp_mon.bus_four_bit));
          n += field_differs("status", 32'(want.status), 32'(rsp_mon.status));
          n += field_differs("high_capacity", 32'(want.high_capacity),
                             32'(rsp_mon.high_capacity));
          n += field_differs("card_address", 32'(want.card_address),
                             32'(rsp_mon.card_address));
          mismatch_count += n;
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        due_results.push_back(next_result(req_mon.opcode, req_mon.response,
                                          req_mon.sector, req_mon.block_count));
      end
      results_due = due_results.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SD card sequencer testbench
// Drives card events into the sequencer: a directed bring-up and transfer
// set, then random bring-ups, transfers and stray events under several
// clock and retry settings, with random gaps and stalls on both channels.
// The checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module testbench;
  import sdc_pkg::*;

  localparam int         CycleLimit      = 300000;
  localparam int         ItemsPerSetting = 140;
  localparam int         NumSettings     = 6;
  localparam logic [2:0] OpUnused        = 3'd7;

  // Points at which a bring-up is made to fail.
  localparam int FaultNone   = 0;
  localparam int FaultGoIdle = 1;
  localparam int FaultIfCond = 2;
  localparam int FaultAppCmd = 3;
  localparam int FaultOpCond = 4;
  localparam int FaultCid    = 5;
  localparam int FaultRca    = 6;
  localparam int FaultSelect = 7;
  localparam int FaultBlkLen = 8;

  // Outcomes of the bus width and high-speed steps.
  localparam int BusWide        = 0;
  localparam int BusAppFail     = 1;
  localparam int BusSetFail     = 2;
  localparam int SwitchFast     = 0;
  localparam int SwitchDataFail = 1;
  localparam int SwitchCmdFail  = 2;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [29:0] cfg_wdata_i;

  int unsigned mismatch_count;
  int unsigned results_due;
  int          cycle_count = 0;
  int          event_count = 0;
  int          noise_count = 0;
  int          rx_hold     = 0;
  bit          tx_idle_on;
  bit          rx_idle_on;
  logic [7:0]  retry_limit_now;

  sdc_req_if req_ch();
  sdc_rsp_if rsp_ch();

  sd_card_init_and_transfer_sequencer u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_ch),
    .rsp_o       (rsp_ch)
  );

  sdc_result_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .req_mon        (req_ch),
    .rsp_mon        (rsp_ch),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  // 100 MHz clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one event item after a random gap and waits until it is taken.
  task automatic send_event(input logic [2:0] op, input logic [31:0] rsp_word,
                            input logic [31:0] sec, input logic [15:0] cnt);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 4) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_ch.valid       <= 1'b1;
    req_ch.opcode      <= op;
    req_ch.response    <= rsp_word;
    req_ch.sector      <= sec;
    req_ch.block_count <= cnt;
    do @(posedge clk_i); while (!req_ch.ready);
    event_count++;
  endtask

  // An event whose other fields carry random content.
  task automatic card_answers(input logic [2:0] op);
    send_event(op, $urandom, $urandom, 16'($urandom));
  endtask

  // Stops offering and waits until every predicted result has come back.
  task automatic drain();
    @(negedge clk_i);
    req_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input sdc_reg_e idx, input logic [29:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    if (idx == REG_RETRY_LIMIT) retry_limit_now = value[7:0];
  endtask

  // Card answers for a full bring-up, stopping early at an injected fault.
  task automatic bring_up(input bit hc, input int not_ready_n, input bit ifcond_err,
                          input int fault, input int bus_path, input int switch_path);
    logic [31:0] w;
    card_answers(OP_START);
    if (fault == FaultGoIdle) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    w = $urandom;
    if (fault == FaultIfCond) begin
      if (w[11:0] == IfCondEcho) w[0] = ~w[0];
      send_event(OP_CMD_OK, w, $urandom, 16'($urandom));
      return;
    end
    if (ifcond_err) begin
      card_answers(OP_CMD_ERR);
    end else begin
      w[11:0] = IfCondEcho;
      send_event(OP_CMD_OK, w, $urandom, 16'($urandom));
    end
    // Card reports busy a number of times before it comes up.
    for (int i = 0; i < not_ready_n; i++) begin
      card_answers(OP_CMD_OK);
      w = $urandom;
      w[31] = 1'b0;
      send_event(OP_CMD_OK, w, $urandom, 16'($urandom));
      if (i + 1 >= int'(retry_limit_now)) return;
    end
    if (fault == FaultAppCmd) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    if (fault == FaultOpCond) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    w = $urandom;
    w[31] = 1'b1;
    w[30] = hc;
    send_event(OP_CMD_OK, w, $urandom, 16'($urandom));
    if (fault == FaultCid) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    if (fault == FaultRca) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    if (fault == FaultSelect) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    if (!hc) begin
      if (fault == FaultBlkLen) begin
        card_answers(OP_CMD_ERR);
        return;
      end
      card_answers(OP_CMD_OK);
    end
    case (bus_path)
      BusWide: begin
        card_answers(OP_CMD_OK);
        card_answers(OP_CMD_OK);
      end
      BusAppFail: card_answers(OP_CMD_ERR);
      default: begin
        card_answers(OP_CMD_OK);
        card_answers(OP_CMD_ERR);
      end
    endcase
    case (switch_path)
      SwitchFast: begin
        card_answers(OP_CMD_OK);
        card_answers(OP_DATA_OK);
      end
      SwitchDataFail: begin
        card_answers(OP_CMD_OK);
        card_answers(OP_DATA_ERR);
      end
      default: card_answers(OP_CMD_ERR);
    endcase
  endtask

  task automatic random_bring_up();
    int nr;
    int fault;
    nr = $urandom_range(0, 3);
    if (nr >= int'(retry_limit_now) && $urandom_range(0, 3) != 0) nr = 0;
    if ($urandom_range(0, 7) == 0 && retry_limit_now <= 20) nr = int'(retry_limit_now);
    fault = ($urandom_range(0, 4) == 0) ? $urandom_range(FaultGoIdle, FaultBlkLen) : FaultNone;
    bring_up(1'($urandom_range(0, 1)), nr, $urandom_range(0, 3) == 0, fault,
             $urandom_range(BusWide, BusSetFail), $urandom_range(SwitchFast, SwitchCmdFail));
  endtask

  // One read or write request with the card's answers to it.
  task automatic transfer();
    logic [2:0]  dir;
    logic [15:0] cnt;
    int          pick;
    dir  = $urandom_range(0, 1) ? OP_READ_REQ : OP_WRITE_REQ;
    pick = $urandom_range(0, 9);
    if (pick == 0) cnt = 16'd0;
    else if (pick < 5) cnt = 16'd1;
    else if (pick < 8) cnt = 16'($urandom_range(2, 16));
    else if (pick == 8) cnt = 16'($urandom);
    else cnt = 16'hFFFF;
    send_event(dir, $urandom, $urandom, cnt);
    if (cnt == 16'd0) return;
    if ($urandom_range(0, 9) == 0) card_answers(dir);
    if ($urandom_range(0, 7) == 0) begin
      card_answers(OP_CMD_ERR);
      return;
    end
    card_answers(OP_CMD_OK);
    if ($urandom_range(0, 9) == 0) card_answers(OP_READ_REQ);
    card_answers(($urandom_range(0, 4) == 0) ? OP_DATA_ERR : OP_DATA_OK);
  endtask

  // A stray event, mostly out of place for the current phase.
  task automatic noise();
    logic [2:0] op;
    op = ($urandom_range(0, 15) == 0) ? OP_START : 3'($urandom_range(1, 7));
    card_answers(op);
    noise_count++;
  endtask

  task automatic random_mix(input int count);
    int goal;
    int pick;
    goal = event_count - noise_count + count;
    random_bring_up();
    while (event_count - noise_count < goal) begin
      pick = $urandom_range(0, 19);
      if (pick < 3) random_bring_up();
      else if (pick < 18) transfer();
      else noise();
    end
  endtask

  // Result side: random stall per item, or a long hold-off when asked.
  initial begin : result_sink
    int wait_n;
    rsp_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        wait_n  = rx_hold;
        rx_hold = 0;
      end else begin
        wait_n = rx_idle_on ? $urandom_range(0, 4) : 0;
      end
      @(negedge clk_i);
      if (wait_n > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (wait_n) @(negedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_ch.valid);
    end
  end

  // Event side: directed set, then random phases under several settings.
  initial begin : stimulus
    logic [29:0] bases  [NumSettings];
    logic [7:0]  limits [NumSettings];
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_BASE_CLOCK;
    cfg_wdata_i        = '0;
    req_ch.valid       = 1'b0;
    req_ch.opcode      = OP_START;
    req_ch.response    = '0;
    req_ch.sector      = '0;
    req_ch.block_count = '0;
    tx_idle_on         = 1'b1;
    rx_idle_on         = 1'b1;
    retry_limit_now    = 8'd99;

    bases  = '{30'd1, 30'd1000000000, 30'd400000, 30'd50000000,
               30'($urandom_range(1, 1000000000)), 30'($urandom_range(1, 1000000000))};
    limits = '{8'd1, 8'd255, 8'd3, 8'd20, 8'($urandom_range(1, 255)), 8'd99};

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // A read request and an undefined event before the card is set up.
    card_answers(OP_READ_REQ);
    card_answers(OpUnused);
    // Standard capacity bring-up with one busy answer, 4-bit bus, high speed.
    bring_up(1'b0, 1, 1'b0, FaultNone, BusWide, SwitchFast);
    // Empty request, single read at the top sector, long write, short write.
    send_event(OP_READ_REQ, $urandom, $urandom, 16'd0);
    send_event(OP_READ_REQ, $urandom, 32'hFFFF_FFFF, 16'd1);
    card_answers(OP_CMD_OK);
    card_answers(OP_DATA_OK);
    send_event(OP_WRITE_REQ, $urandom, $urandom, 16'hFFFF);
    card_answers(OP_READ_REQ);
    card_answers(OP_CMD_OK);
    card_answers(OP_DATA_ERR);
    send_event(OP_WRITE_REQ, $urandom, 32'd0, 16'd2);
    card_answers(OP_CMD_ERR);
    drain();

    for (int k = 0; k < NumSettings; k++) begin
      drain();
      write_reg(REG_BASE_CLOCK, bases[k]);
      write_reg(REG_RETRY_LIMIT, 30'(limits[k]));
      tx_idle_on = (k != 1);
      rx_idle_on = (k != 1 && k != 3);
      if (k == 2) begin
        // Hold the result side off while events keep coming back to back.
        random_bring_up();
        tx_idle_on = 1'b0;
        rx_hold    = 80;
        repeat (6) transfer();
        drain();
        tx_idle_on = 1'b1;
      end
      random_mix(ItemsPerSetting);
    end

    drain();
    repeat (8) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
